// ===== hdl/ppcg_pkg.sv =====
// Shared definitions for the plasma pixel color generator.
// Holds pattern codes, controller command types, constants and sine helpers.
// No dependencies.
package ppcg_pkg;

	localparam int COLUMN_COUNT_DEF = 32;
	localparam int ROW_COUNT_DEF    = 32;

	// pattern register codes
	localparam logic [3:0] PAT_RINGS      = 4'd0;
	localparam logic [3:0] PAT_PLASMA1    = 4'd1;
	localparam logic [3:0] PAT_PLASMA2    = 4'd2;
	localparam logic [3:0] PAT_PLASMA3    = 4'd3;
	localparam logic [3:0] PAT_PLASMA4    = 4'd4;
	localparam logic [3:0] PAT_PASTEL1    = 4'd5;
	localparam logic [3:0] PAT_PASTEL4    = 4'd8;
	localparam logic [3:0] PAT_TERM_X     = 4'd9;
	localparam logic [3:0] PAT_TERM_CROSS = 4'd10;
	localparam logic [3:0] PAT_TERM_DIAG  = 4'd11;
	localparam logic [3:0] PAT_TERM_RING  = 4'd12;
	localparam logic [3:0] PASTEL_OFS     = 4'd4;

	// phase step constants (16-bit turn)
	localparam logic [15:0] STEP_Q4    = 16'd2607;
	localparam logic [15:0] STEP_Q8    = 16'd1303;
	localparam logic [15:0] STEP_R16   = 16'd651;
	localparam logic [15:0] STEP_R32   = 16'd325;
	localparam logic [15:0] STEP_R2    = 16'd5215;
	localparam logic [15:0] STEP_RING  = 16'd1000;
	localparam logic [15:0] STEP_CROSS = 16'd10;
	localparam logic [15:0] QUARTER    = 16'h4000;

	localparam int          ROOT_LIMIT_INT = 65536 / 3;
	localparam logic [15:0] ROOT_LIMIT     = 16'(ROOT_LIMIT_INT);
	localparam logic [30:0] DIV3_MAGIC     = 31'h5555_5556;
	localparam logic [9:0]  RECIP3         = 10'd683;

	localparam logic [15:0] SINE_BASE [0:7] = '{16'd0, 16'd6393, 16'd12539, 16'd18204,
		16'd23170, 16'd27245, 16'd30273, 16'd32137};
	localparam logic [5:0] SINE_SLOPE [0:7] = '{6'd49, 6'd48, 6'd44, 6'd38,
		6'd31, 6'd23, 6'd14, 6'd4};
	localparam logic [6:0] SINE8_TBL [0:7] = '{7'd0, 7'd49, 7'd49, 7'd41,
		7'd90, 7'd27, 7'd117, 7'd10};

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV,
		OP_SINE,
		OP_PREP,
		OP_ROOT,
		OP_PHASE,
		OP_WAVE,
		OP_VALUE,
		OP_THETA,
		OP_COLOR
	} ppcg_op_t;

	typedef struct packed {
		ppcg_op_t   op;
		logic [2:0] idx;
	} ppcg_cmd_t;

	// magnitude of the piecewise-linear 16-bit sine; sign is phase bit 15
	function automatic logic [15:0] sine16_mag(input logic [15:0] a);
		logic [10:0] off;
		logic [2:0]  sec;
		logic [6:0]  frac;
		off = a[13:3];
		if (a[14]) begin
			off = 11'd2047 - off;
		end
		sec  = off[10:8];
		frac = off[7:1];
		return SINE_BASE[sec] + 16'(16'(SINE_SLOPE[sec]) * 16'(frac));
	endfunction

	// 8-bit sine, 128 +/- 127
	function automatic logic [7:0] sine8(input logic [7:0] theta);
		logic [7:0]  off;
		logic [4:0]  sub;
		logic [1:0]  sec;
		logic [11:0] p;
		logic [7:0]  y;
		off = theta[6] ? 8'd255 - theta : theta;
		sub = {1'b0, off[3:0]} + {4'd0, theta[6]};
		sec = off[5:4];
		p   = 12'(SINE8_TBL[{sec, 1'b1}]) * 12'(sub);
		y   = 8'(p >> 4) + {1'b0, SINE8_TBL[{sec, 1'b0}]};
		return theta[7] ? 8'd128 - y : 8'd128 + y;
	endfunction

endpackage

// ===== hdl/ppcg_root.sv =====
// Ceiling square root of a 16-bit value, one result bit per step.
// Saturates to 255 above 21845. Depends on ppcg_pkg.
module ppcg_root import ppcg_pkg::*; (
	input  logic        clk,
	input  logic        start,
	input  logic        step,
	input  logic [2:0]  bit_idx,
	input  logic [15:0] value,
	output logic [7:0]  root
);

	logic [15:0] v_q;
	logic [7:0]  r_q;
	logic [7:0]  trial;
	logic [15:0] trial_sq;

	assign trial    = r_q | (8'd1 << bit_idx);
	assign trial_sq = 16'(16'(trial) * 16'(trial));

	// floor root of (v - 1), built greedily from the top bit
	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= value;
			r_q <= '0;
		end else if (step && trial_sq < v_q) begin
			r_q <= trial;
		end
	end

	always_comb begin
		if (v_q == 16'd0) begin
			root = 8'd0;
		end else if (v_q > ROOT_LIMIT) begin
			root = 8'd255;
		end else begin
			root = r_q + 8'd1;
		end
	end

endmodule

// ===== hdl/ppcg_dp.sv =====
// Datapath: pattern register, operand registers, shared sine unit, two root units,
// wave accumulator and color stage. Driven by ppcg_ctrl commands; uses ppcg_pkg.
module ppcg_dp import ppcg_pkg::*; #(
	parameter int COLUMN_COUNT = COLUMN_COUNT_DEF,
	parameter int ROW_COUNT    = ROW_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pattern_we,
	input  logic [3:0] pattern_wdata,
	input  logic [4:0] column,
	input  logic [4:0] row,
	input  logic [30:0] frame_time,
	input  ppcg_cmd_t  cmd,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);

	logic [3:0]  pattern_q;
	logic [3:0]  pat_q;
	logic [3:0]  vp;
	logic [4:0]  x_q;
	logic [4:0]  y_q;
	logic [30:0] t_q;
	logic [15:0] t3_q;
	logic [61:0] div_prod;
	logic [3:0]  sneg_q;
	logic [15:0] smag_q [4];
	logic [15:0] phase_s;
	logic [15:0] a_q;
	logic [15:0] phase_q;
	logic [15:0] phase_w;
	logic [9:0]  acc_q;
	logic [7:0]  val_q;
	logic [7:0]  thg_q;
	logic [7:0]  thb_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= PAT_RINGS;
		end else if (pattern_we) begin
			pattern_q <= pattern_wdata;
		end
	end

	// pastel patterns reuse the plasma value formulas
	always_comb begin
		if (pat_q >= PAT_PASTEL1 && pat_q <= PAT_PASTEL4) begin
			vp = pat_q - PASTEL_OFS;
		end else begin
			vp = pat_q;
		end
	end

	assign div_prod = 62'(t_q) * 62'(DIV3_MAGIC);

	// phase for the four stored sines: two radius offsets, cross sine, cross cosine
	always_comb begin
		case (cmd.idx[1:0])
			2'd0:    phase_s = (vp == PAT_RINGS) ? t_q[17:2] : t_q[18:3];
			2'd1:    phase_s = (vp == PAT_RINGS) ? t3_q : t_q[19:4];
			2'd2:    phase_s = (vp == PAT_PLASMA4) ? t3_q : t_q[16:1];
			default: phase_s = ((vp == PAT_PLASMA4) ? t_q[17:2] : t3_q) + QUARTER;
		endcase
	end

	// prep: offset centers, squared radii, cross term
	logic [4:0]         ox_m;
	logic [4:0]         oy_m;
	logic signed [7:0]  cx;
	logic signed [7:0]  cy;
	logic signed [9:0]  dx;
	logic signed [9:0]  dy;
	logic signed [9:0]  dxr;
	logic signed [9:0]  dyr;
	logic signed [9:0]  xo;
	logic signed [9:0]  yo;
	logic [15:0]        sq_c;
	logic [15:0]        sq_p;
	logic [15:0]        sq_o;
	logic [15:0]        v1;
	logic [20:0]        xp;
	logic [20:0]        yp;
	logic [15:0]        xs;
	logic [15:0]        ys;
	logic [15:0]        a_s;

	always_comb begin
		ox_m = (vp == PAT_RINGS) ? 5'(smag_q[0] >> 11) : 5'(smag_q[0] >> 10);
		oy_m = (vp == PAT_RINGS) ? 5'(smag_q[1] >> 11) : 5'(smag_q[1] >> 10);
		cx   = sneg_q[0] ? ({3'd0, x_q} - {3'd0, ox_m}) : ({3'd0, x_q} + {3'd0, ox_m});
		cy   = sneg_q[1] ? ({3'd0, y_q} - {3'd0, oy_m}) : ({3'd0, y_q} + {3'd0, oy_m});
		sq_c = 16'(16'(cx) * 16'(cx)) + 16'(16'(cy) * 16'(cy));
		sq_p = 16'(16'(x_q) * 16'(x_q)) + 16'(16'(y_q) * 16'(y_q));
		dx   = $signed({5'd0, x_q}) - $signed(10'(COLUMN_COUNT));
		dy   = $signed({5'd0, y_q}) - $signed(10'(ROW_COUNT));
		dxr  = dx + $signed({9'd0, dx[9]});
		dyr  = dy + $signed({9'd0, dy[9]});
		xo   = dxr >>> 1;
		yo   = dyr >>> 1;
		sq_o = 16'(16'(xo) * 16'(xo)) + 16'(16'(yo) * 16'(yo));
		case (vp) inside
			PAT_RINGS, PAT_PLASMA3, PAT_PLASMA4: v1 = sq_c;
			default:                             v1 = sq_p;
		endcase
		xp  = 21'(x_q) * 21'(smag_q[2]);
		yp  = 21'(y_q) * 21'(smag_q[3]);
		xs  = 16'(xp[20:8]);
		ys  = 16'(yp[20:8]);
		a_s = (sneg_q[2] ? 16'd0 - xs : xs) + (sneg_q[3] ? 16'd0 - ys : ys);
	end

	logic [7:0] r1;
	logic [7:0] r2;

	ppcg_root u_root_main (
		.clk     (clk),
		.start   (cmd.op == OP_PREP),
		.step    (cmd.op == OP_ROOT),
		.bit_idx (cmd.idx),
		.value   (v1),
		.root    (r1)
	);

	ppcg_root u_root_ofs (
		.clk     (clk),
		.start   (cmd.op == OP_PREP),
		.step    (cmd.op == OP_ROOT),
		.bit_idx (cmd.idx),
		.value   (sq_o),
		.root    (r2)
	);

	// phase of wave term idx for the active formula
	always_comb begin
		phase_w = '0;
		case (vp)
			PAT_PLASMA1: begin
				case (cmd.idx[1:0])
					2'd0:    phase_w = 16'(x_q * STEP_Q4) + t_q[17:2];
					2'd1:    phase_w = 16'(y_q * STEP_Q4) + t_q[17:2];
					2'd2:    phase_w = 16'((x_q + y_q) * STEP_Q8) + t_q[18:3];
					default: phase_w = 16'(r1 * STEP_RING) + t_q[15:0];
				endcase
			end
			PAT_PLASMA2: begin
				case (cmd.idx[1:0])
					2'd0:    phase_w = 16'(x_q * STEP_R16);
					2'd1:    phase_w = 16'(y_q * STEP_R32);
					2'd2:    phase_w = 16'(r2 * STEP_RING);
					default: phase_w = 16'(r1 * STEP_RING) + t_q[15:0];
				endcase
			end
			PAT_PLASMA3: begin
				case (cmd.idx[1:0])
					2'd0:    phase_w = 16'(x_q * STEP_Q8) + t_q[17:2];
					2'd1:    phase_w = 16'(a_q * STEP_CROSS);
					2'd2:    phase_w = 16'((x_q + y_q) * STEP_Q8) + t_q[18:3];
					default: phase_w = 16'(r1 * STEP_R2) + t_q[15:0];
				endcase
			end
			PAT_PLASMA4: begin
				case (cmd.idx[1:0])
					2'd0:    phase_w = 16'(x_q * STEP_Q4) + t_q[15:0];
					2'd1:    phase_w = 16'(a_q * STEP_CROSS);
					2'd2:    phase_w = 16'(r1 * STEP_Q8) + t_q[15:0];
					default: phase_w = '0;
				endcase
			end
			PAT_TERM_X:     phase_w = 16'(x_q * STEP_Q8) + t_q[17:2];
			PAT_TERM_CROSS: phase_w = 16'(a_q * STEP_CROSS);
			PAT_TERM_DIAG:  phase_w = 16'((x_q + y_q) * STEP_Q8) + t_q[18:3];
			PAT_TERM_RING:  phase_w = 16'(r1 * STEP_RING) + t_q[15:0];
			PAT_RINGS:      phase_w = 16'(r1 * STEP_Q8) + t_q[16:1];
			default:        phase_w = '0;
		endcase
	end

	// wave term: 128 + sine / 256 (or / 512), truncated toward zero
	logic        w_used;
	logic        w_half;
	logic [15:0] w_mag;
	logic [7:0]  w_div;
	logic [9:0]  w_val;

	always_comb begin
		case (vp) inside
			PAT_PLASMA1, PAT_PLASMA2, PAT_PLASMA3: w_used = 1'b1;
			PAT_PLASMA4:                           w_used = (cmd.idx[1:0] != 2'd3);
			PAT_RINGS, [PAT_TERM_X:PAT_TERM_RING]: w_used = (cmd.idx[1:0] == 2'd0);
			default:                               w_used = 1'b0;
		endcase
		w_half = (vp == PAT_PLASMA3 && cmd.idx[1:0] == 2'd3)
			|| (vp == PAT_PLASMA4 && cmd.idx[1:0] == 2'd2);
		w_mag = sine16_mag(phase_q);
		w_div = w_half ? 8'(w_mag >> 9) : 8'(w_mag >> 8);
		w_val = phase_q[15] ? 10'd128 - 10'(w_div) : 10'd128 + 10'(w_div);
	end

	// value and pastel angles
	logic [19:0] acc_prod;
	logic [7:0]  val_s;
	logic [19:0] tg_prod;
	logic [19:0] tb_prod;

	always_comb begin
		acc_prod = 20'(acc_q) * 20'(RECIP3);
		case (vp) inside
			PAT_PLASMA1, PAT_PLASMA2: val_s = acc_q[9:2];
			PAT_PLASMA3, PAT_PLASMA4: val_s = 8'(acc_prod >> 11);
			default:                  val_s = acc_q[7:0];
		endcase
		tg_prod = 20'({val_q, 1'b0}) * 20'(RECIP3);
		tb_prod = 20'({val_q, 2'b0}) * 20'(RECIP3);
	end

	// hue to RGB at full saturation and value; pastel patterns pass the value and two angles through the 8-bit sine
	logic [2:0]  region;
	logic [7:0]  hbase;
	logic [7:0]  hdiff;
	logic [7:0]  rem;
	logic [7:0]  rem_n;
	logic [15:0] m_q;
	logic [15:0] m_t;
	logic [7:0]  in_q;
	logic [7:0]  in_t;
	logic [15:0] o_q;
	logic [15:0] o_t;
	logic [7:0]  hq;
	logic [7:0]  ht;
	logic [7:0]  r_s;
	logic [7:0]  g_s;
	logic [7:0]  b_s;

	always_comb begin
		if (val_q < 8'd43) begin
			region = 3'd0;
			hbase  = 8'd0;
		end else if (val_q < 8'd86) begin
			region = 3'd1;
			hbase  = 8'd43;
		end else if (val_q < 8'd129) begin
			region = 3'd2;
			hbase  = 8'd86;
		end else if (val_q < 8'd172) begin
			region = 3'd3;
			hbase  = 8'd129;
		end else if (val_q < 8'd215) begin
			region = 3'd4;
			hbase  = 8'd172;
		end else begin
			region = 3'd5;
			hbase  = 8'd215;
		end
		hdiff = val_q - hbase;
		rem   = 8'(hdiff * 8'd6);
		rem_n = 8'd255 - rem;
		m_q   = {rem, 8'd0} - {8'd0, rem};
		m_t   = {rem_n, 8'd0} - {8'd0, rem_n};
		in_q  = 8'd255 - m_q[15:8];
		in_t  = 8'd255 - m_t[15:8];
		o_q   = {in_q, 8'd0} - {8'd0, in_q};
		o_t   = {in_t, 8'd0} - {8'd0, in_t};
		hq    = o_q[15:8];
		ht    = o_t[15:8];

		r_s = 8'd0;
		g_s = 8'd0;
		b_s = 8'd0;
		case (pat_q) inside
			[PAT_RINGS:PAT_PLASMA4], [PAT_TERM_X:PAT_TERM_RING]: begin
				case (region)
					3'd0: begin
						r_s = 8'd255;
						g_s = ht;
					end
					3'd1: begin
						r_s = hq;
						g_s = 8'd255;
					end
					3'd2: begin
						g_s = 8'd255;
						b_s = ht;
					end
					3'd3: begin
						g_s = hq;
						b_s = 8'd255;
					end
					3'd4: begin
						r_s = ht;
						b_s = 8'd255;
					end
					default: begin
						r_s = 8'd255;
						b_s = hq;
					end
				endcase
			end
			[PAT_PASTEL1:PAT_PASTEL4]: begin
				r_s = sine8(val_q);
				g_s = sine8(thg_q);
				b_s = sine8(thb_q);
			end
			default: begin
				r_s = 8'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				x_q   <= column;
				y_q   <= row;
				t_q   <= frame_time;
				pat_q <= pattern_q;
			end
			OP_DIV: begin
				t3_q <= div_prod[47:32];
			end
			OP_SINE: begin
				sneg_q[cmd.idx[1:0]] <= phase_s[15];
				smag_q[cmd.idx[1:0]] <= sine16_mag(phase_s);
			end
			OP_PREP: begin
				a_q   <= a_s;
				acc_q <= '0;
			end
			OP_PHASE: begin
				phase_q <= phase_w;
			end
			OP_WAVE: begin
				if (w_used) begin
					acc_q <= acc_q + w_val;
				end
			end
			OP_VALUE: begin
				val_q <= val_s;
			end
			OP_THETA: begin
				thg_q <= val_q + 8'(tg_prod >> 11);
				thb_q <= val_q + 8'(tb_prod >> 11);
			end
			OP_COLOR: begin
				red_q   <= r_s;
				green_q <= g_s;
				blue_q  <= b_s;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign red   = red_q;
	assign green = green_q;
	assign blue  = blue_q;

endmodule

// ===== hdl/ppcg_ctrl.sv =====
// Controller: sequences one pixel request through the datapath and owns both handshakes.
// Depends on ppcg_pkg for the command type.
module ppcg_ctrl import ppcg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pixel_valid,
	output logic      pixel_stall,
	output logic      color_valid,
	input  logic      color_stall,
	output ppcg_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_SINE,
		S_PREP,
		S_ROOT,
		S_PHASE,
		S_WAVE,
		S_VALUE,
		S_THETA,
		S_COLOR
	} state_t;

	state_t     state_q;
	logic [2:0] cnt_q;
	logic       color_valid_q;
	logic       accept;
	logic       out_free;

	assign pixel_stall = (state_q != S_IDLE);
	assign accept      = pixel_valid && !pixel_stall;
	assign out_free    = !color_valid_q || !color_stall;
	assign color_valid = color_valid_q;

	always_comb begin
		cmd.idx = cnt_q;
		unique case (state_q)
			S_IDLE:  cmd.op = accept ? OP_LOAD : OP_NONE;
			S_DIV:   cmd.op = OP_DIV;
			S_SINE:  cmd.op = OP_SINE;
			S_PREP:  cmd.op = OP_PREP;
			S_ROOT:  cmd.op = OP_ROOT;
			S_PHASE: cmd.op = OP_PHASE;
			S_WAVE:  cmd.op = OP_WAVE;
			S_VALUE: cmd.op = OP_VALUE;
			S_THETA: cmd.op = OP_THETA;
			S_COLOR: cmd.op = out_free ? OP_COLOR : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			color_valid_q <= 1'b0;
		end else begin
			if (color_valid_q && !color_stall) begin
				color_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					state_q <= S_SINE;
					cnt_q   <= '0;
				end
				S_SINE: begin
					if (cnt_q == 3'd3) begin
						state_q <= S_PREP;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_PREP: begin
					state_q <= S_ROOT;
					cnt_q   <= 3'd7;
				end
				S_ROOT: begin
					if (cnt_q == 3'd0) begin
						state_q <= S_PHASE;
					end else begin
						cnt_q <= cnt_q - 3'd1;
					end
				end
				S_PHASE: begin
					state_q <= S_WAVE;
				end
				S_WAVE: begin
					if (cnt_q == 3'd3) begin
						state_q <= S_VALUE;
					end else begin
						state_q <= S_PHASE;
						cnt_q   <= cnt_q + 3'd1;
					end
				end
				S_VALUE: begin
					state_q <= S_THETA;
				end
				S_THETA: begin
					state_q <= S_COLOR;
				end
				S_COLOR: begin
					if (out_free) begin
						color_valid_q <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> pixel_stall)
		else $error("accepted request did not make the block busy");

	a_result_from_color: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(color_valid_q) |-> $past(state_q == S_COLOR))
		else $error("result raised outside the color step");

	a_hold_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COLOR && color_valid_q && color_stall)
		|=> (state_q == S_COLOR && color_valid_q))
		else $error("pending result overwritten");

endmodule

// ===== hdl/plasma_pixel_color_generator.sv =====
// Plasma pixel color generator: one RGB color per pixel request.
// The sequencer runs the time division, four stored sines, the eight-step root units and the four wave terms
// in order, and takes no new request until it has handed the previous color to the output register.
// A finished color waits in the output register; a new request is taken meanwhile.
// Reset (arst_n low, asynchronous) clears the sequencer, the output valid and pattern to 0.
// Depends on ppcg_pkg, ppcg_ctrl, ppcg_dp and ppcg_root.
module plasma_pixel_color_generator import ppcg_pkg::*; #(
	parameter int COLUMN_COUNT = COLUMN_COUNT_DEF,
	parameter int ROW_COUNT    = ROW_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// pattern register write
	input  logic        pattern_we,
	input  logic [3:0]  pattern_wdata,
	// pixel request
	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  logic [4:0]  column,
	input  logic [4:0]  row,
	input  logic [30:0] frame_time,
	// color result
	output logic        color_valid,
	input  logic        color_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);

	// Command from the sequencer to the datapath, one step per cycle except while the color step waits for the receiver:
	// load operands, divide time by three, four stored sines, prep squares,
	// eight root steps, four phase/wave pairs, value, pastel angles, color.
	ppcg_cmd_t cmd;

	ppcg_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.color_valid (color_valid),
		.color_stall (color_stall),
		.cmd         (cmd)
	);

	// Datapath holds the pattern register; it is sampled when a request loads,
	// so a write only ever affects later pixels.
	ppcg_dp #(
		.COLUMN_COUNT (COLUMN_COUNT),
		.ROW_COUNT    (ROW_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.pattern_we    (pattern_we),
		.pattern_wdata (pattern_wdata),
		.column        (column),
		.row           (row),
		.frame_time    (frame_time),
		.cmd           (cmd),
		.red           (red),
		.green         (green),
		.blue          (blue)
	);

endmodule

// ===== tb/plasma_pixel_color_generator_tb.sv =====
// Self-checking testbench for plasma_pixel_color_generator.
// Predicts each pixel color from coordinates, frame time and the pattern register,
// and compares it with the block's output. Depends on ppcg_pkg and the block's RTL.
`timescale 1ns / 1ps

module plasma_pixel_color_generator_tb;
	import ppcg_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int WATCHDOG_MAX = 20000;
	localparam int MAX_REPORTS  = 10;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_OFF_LEN = 400;

	typedef struct packed {
		logic [4:0]  column;
		logic [4:0]  row;
		logic [30:0] frame_time;
	} pixel_req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} color_t;

	logic        clk;
	logic        arst_n;
	logic        pattern_we;
	logic [3:0]  pattern_wdata;
	logic        pixel_valid = 1'b0;
	logic        pixel_stall;
	logic [4:0]  column = '0;
	logic [4:0]  row = '0;
	logic [30:0] frame_time = '0;
	logic        color_valid;
	logic        color_stall = 1'b0;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;

	// idling mix, percent per cycle
	int          send_idle_pct;
	int          recv_stall_pct;
	// long hold-off: the stimulus bumps the request count, the stall process counts
	int          hold_off_req = 0;
	int          hold_off_seen = 0;
	int          hold_off_cycles = 0;

	pixel_req_t  pending_reqs[$];
	color_t      expected_colors[$];
	logic [3:0]  model_pattern;
	int          mismatch_count = 0;
	int          color_count = 0;
	int          quiet_cycles = 0;
	logic        in_fire;

	plasma_pixel_color_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pattern_we   (pattern_we),
		.pattern_wdata(pattern_wdata),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.column       (column),
		.row          (row),
		.frame_time   (frame_time),
		.color_valid  (color_valid),
		.color_stall  (color_stall),
		.red          (red),
		.green        (green),
		.blue         (blue)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// ---------------- color predictor ----------------

	// piecewise-linear 16-bit sine, signed result
	function automatic int sin16(input int unsigned phase);
		logic [15:0] a;
		int          mag;
		a   = phase[15:0];
		mag = int'(sine16_mag(a));
		return a[15] ? -mag : mag;
	endfunction

	function automatic int cos16(input int unsigned phase);
		return sin16(phase + 32'(QUARTER));
	endfunction

	// ceiling square root of a 16-bit value, saturating to 255 above the limit
	function automatic int unsigned ceil_root(input int unsigned v);
		int unsigned r;
		int unsigned m;
		m = v & 32'hFFFF;
		r = 0;
		if (m > 32'(ROOT_LIMIT_INT)) return 255;
		while (r * r < m) r++;
		return r;
	endfunction

	// 8-bit sine, written independently of the package helper
	function automatic int unsigned sin8(input int unsigned theta);
		int unsigned t, off, sub, sec, y;
		int unsigned tbl[8];
		tbl = '{0, 49, 49, 41, 90, 27, 117, 10};
		t   = theta & 8'hFF;
		off = t;
		if (t & 32'h40) off = 255 - off;
		off = off & 32'h3F;
		sub = off & 32'h0F;
		if (t & 32'h40) sub++;
		sec = off >> 4;
		y   = ((tbl[2 * sec + 1] * sub) >> 4) + tbl[2 * sec];
		return (t & 32'h80) ? 128 - y : 128 + y;
	endfunction

	function automatic int wave_term(input int unsigned phase, input int divisor);
		return 128 + sin16(phase) / divisor;
	endfunction

	function automatic int cross_wave(input int unsigned x, input int unsigned y,
			input int unsigned ts, input int unsigned tc);
		int a;
		a = int'(x) * sin16(ts) / 256 + int'(y) * cos16(tc) / 256;
		return wave_term(32'(10 * a), 256);
	endfunction

	function automatic int unsigned drift_radius(input int unsigned x, input int unsigned y,
			input int unsigned tx, input int unsigned ty, input int divisor);
		int unsigned cx, cy;
		cx = 32'(int'(x) + sin16(tx) / divisor) & 32'hFFFF;
		cy = 32'(int'(y) + sin16(ty) / divisor) & 32'hFFFF;
		return ceil_root(cx * cx + cy * cy);
	endfunction

	function automatic int unsigned pattern_value(input logic [3:0] pat,
			input int unsigned x, input int unsigned y, input int unsigned t);
		int unsigned q4, q8;
		int          sum, xo, yo;
		q4 = 32'(STEP_Q4);
		q8 = 32'(STEP_Q8);
		case (pat)
			PAT_PLASMA1: begin
				sum = wave_term(x * q4 + t / 4, 256) + wave_term(y * q4 + t / 4, 256)
					+ wave_term((x + y) * q8 + t / 8, 256)
					+ wave_term(ceil_root(x * x + y * y) * 1000 + t, 256);
				return 32'(sum / 4) & 8'hFF;
			end
			PAT_PLASMA2: begin
				xo  = (int'(x) - COLUMN_COUNT_DEF) / 2;
				yo  = (int'(y) - ROW_COUNT_DEF) / 2;
				sum = wave_term(x * 32'(STEP_R16), 256) + wave_term(y * 32'(STEP_R32), 256)
					+ wave_term(ceil_root(32'(xo * xo + yo * yo)) * 1000, 256)
					+ wave_term(ceil_root(x * x + y * y) * 1000 + t, 256);
				return 32'(sum / 4) & 8'hFF;
			end
			PAT_PLASMA3: begin
				sum = wave_term(x * q8 + t / 4, 256) + cross_wave(x, y, t / 2, t / 3)
					+ wave_term((x + y) * q8 + t / 8, 256)
					+ wave_term(drift_radius(x, y, t / 8, t / 16, 1024) * 32'(STEP_R2) + t,
						512);
				return 32'(sum / 3) & 8'hFF;
			end
			PAT_PLASMA4: begin
				sum = wave_term(x * q4 + t, 256) + cross_wave(x, y, t / 3, t / 4)
					+ wave_term(drift_radius(x, y, t / 8, t / 16, 1024) * q8 + t, 512);
				return 32'(sum / 3) & 8'hFF;
			end
			PAT_TERM_X:     return 32'(wave_term(x * q8 + t / 4, 256)) & 8'hFF;
			PAT_TERM_CROSS: return 32'(cross_wave(x, y, t / 2, t / 3)) & 8'hFF;
			PAT_TERM_DIAG:  return 32'(wave_term((x + y) * q8 + t / 8, 256)) & 8'hFF;
			PAT_TERM_RING:  return 32'(wave_term(ceil_root(x * x + y * y) * 1000 + t, 256))
				& 8'hFF;
			default: return 32'(wave_term(drift_radius(x, y, t / 4, t / 3, 2048) * q8 + t / 2,
				256)) & 8'hFF;
		endcase
	endfunction

	// full saturation and value HSV to RGB
	function automatic color_t hue_color(input int unsigned hue);
		int unsigned region, rem, fall, rise;
		color_t c;
		region = hue / 43;
		rem    = (hue - region * 43) * 6;
		fall   = (255 * (255 - ((255 * rem) >> 8))) >> 8;
		rise   = (255 * (255 - ((255 * (255 - rem)) >> 8))) >> 8;
		case (region)
			0:       c = '{8'd255, 8'(rise), 8'd0};
			1:       c = '{8'(fall), 8'd255, 8'd0};
			2:       c = '{8'd0, 8'd255, 8'(rise)};
			3:       c = '{8'd0, 8'(fall), 8'd255};
			4:       c = '{8'(rise), 8'd0, 8'd255};
			default: c = '{8'd255, 8'd0, 8'(fall)};
		endcase
		return c;
	endfunction

	function automatic color_t predict_color(input logic [3:0] pat, input pixel_req_t req);
		int unsigned v;
		color_t      c;
		c = '0;
		if (pat <= PAT_PLASMA4 || (pat >= PAT_TERM_X && pat <= PAT_TERM_RING)) begin
			c = hue_color(pattern_value(pat, req.column, req.row, req.frame_time));
		end else if (pat <= PAT_PASTEL4) begin
			v = pattern_value(pat - PASTEL_OFS, req.column, req.row, req.frame_time);
			c = '{8'(sin8(v)), 8'(sin8(v + 2 * v / 3)), 8'(sin8(v + 4 * v / 3))};
		end
		return c;
	endfunction

	// ---------------- driver ----------------

	// Note an accepted request at the rising edge.
	always @(posedge clk) begin
		in_fire <= arst_n && pixel_valid && !pixel_stall;
	end

	// Drop the accepted request, then advance the next one on the falling edge;
	// hold the current one while stalled.
	always @(negedge clk) begin
		if (!arst_n) begin
			pixel_valid <= 1'b0;
		end else begin
			if (in_fire) begin
				void'(pending_reqs.pop_front());
			end
			if (!pixel_valid || in_fire) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					{column, row, frame_time} <= pending_reqs[0];
					pixel_valid <= 1'b1;
				end else begin
					pixel_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall: a long hold-off when requested, otherwise random.
	always @(negedge clk) begin
		if (!arst_n) begin
			color_stall <= 1'b0;
		end else if (hold_off_req != hold_off_seen) begin
			hold_off_seen   <= hold_off_req;
			hold_off_cycles <= HOLD_OFF_LEN - 1;
			color_stall     <= 1'b1;
		end else if (hold_off_cycles > 0) begin
			color_stall     <= 1'b1;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			color_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// ---------------- monitor ----------------

	always @(posedge clk) begin
		color_t got, want;
		if (arst_n) begin
			// input side: predict on acceptance
			if (pixel_valid && !pixel_stall) begin
				expected_colors.push_back(predict_color(model_pattern,
					'{column, row, frame_time}));
			end
			// output side: compare with the oldest prediction
			if (color_valid && !color_stall) begin
				got = '{red, green, blue};
				color_count++;
				if (expected_colors.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("ERROR: unexpected color r=%0d g=%0d b=%0d",
							red, green, blue);
				end else begin
					want = expected_colors.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("ERROR: pat %0d exp %0d/%0d/%0d got %0d/%0d/%0d",
								model_pattern, want.red, want.green, want.blue,
								red, green, blue);
					end
				end
			end
			if ((pixel_valid && !pixel_stall) || (color_valid && !color_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if (quiet_cycles >= WATCHDOG_MAX) begin
			$display("timeout: no handshake for %0d cycles", WATCHDOG_MAX);
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------- stimulus ----------------

	function automatic pixel_req_t random_req();
		pixel_req_t r;
		r.column = 5'($urandom_range(31));
		r.row    = 5'($urandom_range(31));
		case ($urandom_range(3))
			0:       r.frame_time = 31'($urandom_range(4095));
			1:       r.frame_time = 31'h7FFF_FFFF - 31'($urandom_range(4095));
			default: r.frame_time = 31'($urandom());
		endcase
		return r;
	endfunction

	// Wait until every queued request was taken and every color came back.
	task automatic drain();
		while (pending_reqs.size() > 0 || pixel_valid || expected_colors.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write the pattern register while the block is idle.
	task automatic set_pattern(input logic [3:0] pat);
		@(negedge clk);
		pattern_we    <= 1'b1;
		pattern_wdata <= pat;
		@(negedge clk);
		pattern_we    <= 1'b0;
		model_pattern  = pat;
	endtask

	task automatic run_phase(input logic [3:0] pat, input int count,
			input int idle_pct, input int stall_pct);
		set_pattern(pat);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) pending_reqs.push_back(random_req());
		drain();
	endtask

	initial begin
		int idle_mix[4];
		int stall_mix[4];
		idle_mix  = '{0, 57, 0, 15};
		stall_mix = '{0, 0, 57, 15};
		arst_n          = 1'b0;
		pattern_we      = 1'b0;
		pattern_wdata   = '0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		model_pattern   = PAT_RINGS;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset pattern first, then corner coordinates and times
		// on every pattern code, unused codes included (they give black)
		for (int p = 0; p < 16; p++) begin
			if (p != 0) set_pattern(4'(p));
			pending_reqs.push_back('{5'd0, 5'd0, 31'd0});
			pending_reqs.push_back('{5'd31, 5'd31, 31'h7FFF_FFFF});
			if (p < 2) begin
				pending_reqs.push_back('{5'd31, 5'd0, 31'h5555_5555});
				pending_reqs.push_back('{5'd0, 5'd31, 31'h2AAA_AAAA});
				pending_reqs.push_back('{5'd16, 5'd16, 31'd65535});
			end
			drain();
		end

		// random phases across all patterns and idling mixes
		for (int k = 0; k < 64; k++) begin
			run_phase(4'($urandom_range(15)), 25, idle_mix[k % 4], stall_mix[k % 4]);
		end

		// pressure: receiver holds off while the sender keeps offering
		set_pattern(PAT_PLASMA3);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		@(negedge clk);
		hold_off_req = hold_off_req + 1;
		repeat (20) pending_reqs.push_back(random_req());
		drain();

		// extreme pattern codes once more
		run_phase(PAT_RINGS, 25, 15, 15);
		run_phase(4'd15, 25, 0, 0);
		run_phase(PAT_TERM_RING, 25, 57, 57);

		$display("covered %0d colors over all 16 pattern codes, %0d mismatches",
			color_count, mismatch_count);
		$display("idling mixes: none, sender 57%%, receiver 57%%, both 15%%; one long hold-off");
		if (mismatch_count == 0 && expected_colors.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== plasma_pixel_color_generator.f =====
hdl/ppcg_pkg.sv
hdl/ppcg_root.sv
hdl/ppcg_dp.sv
hdl/ppcg_ctrl.sv
hdl/plasma_pixel_color_generator.sv
tb/plasma_pixel_color_generator_tb.sv
